// ===== design/rscd_pkg.sv =====
`timescale 1ns / 1ps

package rscd_pkg;

    localparam int WIDE_CHAIN_BITS_DEF   = 16;
    localparam int NARROW_CHAIN_BITS_DEF = 8;
    localparam int DIRECT_PIN_BIT_DEF    = 24;

    localparam logic [31:0] WIDE_MASK   = 32'h0000_ffff;
    localparam logic [31:0] NARROW_MASK = 32'h00ff_0000;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_WIDE   = 2'd0,
        KIND_NARROW = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] mask_or_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        data_bit;
        logic        latch_after;
        logic        direct_pin;
        logic [31:0] shadow_word;
        logic        any_selected;
        logic        last;
    } out_item_t;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        STEP_FETCH      = 3'd0,
        STEP_WIDE_CHK   = 3'd1,
        STEP_WIDE_BIT   = 3'd2,
        STEP_NARROW_CHK = 3'd3,
        STEP_NARROW_BIT = 3'd4,
        STEP_STATUS     = 3'd5
    } step_t;

    // Jump conditions; the jump is taken when the condition is true.
    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_ALWAYS      = 3'd1,
        COND_NO_INPUT    = 3'd2,
        COND_NO_WIDE     = 3'd3,
        COND_NO_NARROW   = 3'd4,
        COND_MORE_WIDE   = 3'd5,
        COND_MORE_NARROW = 3'd6
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  emit;
        kind_t kind;
        logic  clr_cnt;
        cond_t cond;
        step_t target;
    } uword_t;

    // Control signals from the sequencer to the datapath.
    typedef struct packed {
        logic  take_in;
        logic  emit;
        kind_t kind;
        logic  clr_cnt;
    } ctrl_t;

    // Flags from the datapath back to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic wide;
        logic narrow;
        logic wide_last;
        logic narrow_last;
        logic out_free;
    } flags_t;

    // The microprogram.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{take_in: 1'b0, emit: 1'b0, kind: KIND_STATUS, clr_cnt: 1'b0,
              cond: COND_ALWAYS, target: STEP_FETCH};
        case (s)
            STEP_FETCH:
            begin
                w.take_in = 1'b1;
                w.clr_cnt = 1'b1;
                w.cond    = COND_NO_INPUT;
                w.target  = STEP_FETCH;
            end
            STEP_WIDE_CHK:
            begin
                w.clr_cnt = 1'b1;
                w.cond    = COND_NO_WIDE;
                w.target  = STEP_NARROW_CHK;
            end
            STEP_WIDE_BIT:
            begin
                w.emit   = 1'b1;
                w.kind   = KIND_WIDE;
                w.cond   = COND_MORE_WIDE;
                w.target = STEP_WIDE_BIT;
            end
            STEP_NARROW_CHK:
            begin
                w.clr_cnt = 1'b1;
                w.cond    = COND_NO_NARROW;
                w.target  = STEP_STATUS;
            end
            STEP_NARROW_BIT:
            begin
                w.emit   = 1'b1;
                w.kind   = KIND_NARROW;
                w.cond   = COND_MORE_NARROW;
                w.target = STEP_NARROW_BIT;
            end
            STEP_STATUS:
            begin
                w.emit   = 1'b1;
                w.kind   = KIND_STATUS;
                w.cond   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/relay_shift_chain_driver.sv =====
`timescale 1ns / 1ps

// The first result item is registered from the wide-bit step, which follows the fetch and
// wide-check steps; with no wide shift it comes from the narrow-bit or status step instead.
// A command shifts out N chain bits (0, 8, 16 or 24) and then one status item; the emitting
// steps emit one item per cycle unless the output stalls, and the next command waits for the status step.
// Reset: rst_n clears the shadow word to zero (all relays open), empties the output register
// and returns the sequencer to its fetch step; the block takes a command right after reset.

module relay_shift_chain_driver #(
    parameter int WIDE_CHAIN_BITS   = rscd_pkg::WIDE_CHAIN_BITS_DEF,
    parameter int NARROW_CHAIN_BITS = rscd_pkg::NARROW_CHAIN_BITS_DEF,
    parameter int DIRECT_PIN_BIT    = rscd_pkg::DIRECT_PIN_BIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Command channel: one item per command.
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  rscd_pkg::in_item_t  cmd_item,
    // Result channel: chain bits followed by one status item per command.
    output logic                res_valid,
    input  logic                res_stall,
    output rscd_pkg::out_item_t res_item
);

    // The sequencer steps through a small microprogram held in a constant table. Each
    // control word says whether the step takes a command, emits an item and of which
    // kind, clears the bit counter, and where to jump under which condition.
    rscd_pkg::ctrl_t  ctrl;
    rscd_pkg::flags_t flags;

    // A command is taken only in the fetch step of the program.
    assign cmd_stall = !ctrl.take_in;

    rscd_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // The datapath holds the shadow word, the latched mask and chain flags, the chain
    // bit counter and the output register that decouples the result side.
    rscd_datapath #(
        .WIDE_CHAIN_BITS   (WIDE_CHAIN_BITS),
        .NARROW_CHAIN_BITS (NARROW_CHAIN_BITS),
        .DIRECT_PIN_BIT    (DIRECT_PIN_BIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .res_stall (res_stall),
        .flags     (flags),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

endmodule

// ===== design/rscd_sequencer.sv =====
`timescale 1ns / 1ps

module rscd_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  rscd_pkg::flags_t flags,
    output rscd_pkg::ctrl_t  ctrl
);

    rscd_pkg::step_t  step_reg;
    rscd_pkg::step_t  step_next;
    rscd_pkg::uword_t uw;
    logic             hold;
    logic             jump;

    assign uw = rscd_pkg::ucode(step_reg);

    // Next step: an emitting step waits for room in the output register.
    always_comb
    begin
        hold = uw.emit && !flags.out_free;
        case (uw.cond)
            rscd_pkg::COND_NEVER:       jump = 1'b0;
            rscd_pkg::COND_ALWAYS:      jump = 1'b1;
            rscd_pkg::COND_NO_INPUT:    jump = !flags.in_valid;
            rscd_pkg::COND_NO_WIDE:     jump = !flags.wide;
            rscd_pkg::COND_NO_NARROW:   jump = !flags.narrow;
            rscd_pkg::COND_MORE_WIDE:   jump = !flags.wide_last;
            rscd_pkg::COND_MORE_NARROW: jump = !flags.narrow_last;
            default:                    jump = 1'b1;
        endcase
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = rscd_pkg::step_t'(3'(step_reg) + 3'd1);
        end
    end

    always_comb
    begin
        ctrl.take_in = uw.take_in;
        ctrl.emit    = uw.emit;
        ctrl.kind    = uw.kind;
        ctrl.clr_cnt = uw.clr_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rscd_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The program leaves the fetch step only when a command is there.
    a_fetch_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == rscd_pkg::STEP_FETCH && step_next != rscd_pkg::STEP_FETCH)
            |-> flags.in_valid)
        else $error("sequencer left fetch without a command");

    // An emitting step never advances while the output register is full.
    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.emit && !flags.out_free) |=> $stable(step_reg))
        else $error("sequencer advanced past a blocked emit");
`endif

endmodule

// ===== design/rscd_datapath.sv =====
`timescale 1ns / 1ps

module rscd_datapath #(
    parameter int WIDE_CHAIN_BITS   = rscd_pkg::WIDE_CHAIN_BITS_DEF,
    parameter int NARROW_CHAIN_BITS = rscd_pkg::NARROW_CHAIN_BITS_DEF,
    parameter int DIRECT_PIN_BIT    = rscd_pkg::DIRECT_PIN_BIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rscd_pkg::ctrl_t     ctrl,
    input  logic                cmd_valid,
    input  rscd_pkg::in_item_t  cmd_item,
    input  logic                res_stall,
    output rscd_pkg::flags_t    flags,
    output logic                res_valid,
    output rscd_pkg::out_item_t res_item
);

    localparam int CNT_W = $clog2(WIDE_CHAIN_BITS);

    logic [31:0]         shadow_reg;
    logic [31:0]         shadow_next;
    logic [31:0]         mask_reg;
    logic                wide_reg;
    logic                wide_next;
    logic                narrow_reg;
    logic                narrow_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    rscd_pkg::out_item_t out_item_reg;
    rscd_pkg::out_item_t item_next;

    logic        accept;
    logic        fire;
    logic        out_free;
    logic        wide_last;
    logic        narrow_last;
    logic [4:0]  wide_pos;
    logic [4:0]  narrow_pos;

    assign accept      = cmd_valid && ctrl.take_in;
    assign out_free    = !out_valid_reg || !res_stall;
    assign fire        = ctrl.emit && out_free;
    assign wide_last   = cnt_reg == CNT_W'(WIDE_CHAIN_BITS - 1);
    assign narrow_last = cnt_reg == CNT_W'(NARROW_CHAIN_BITS - 1);

    // Each byte of the wide chain goes out most significant bit first.
    assign wide_pos   = 5'(cnt_reg) ^ 5'd7;
    assign narrow_pos = 5'd23 - 5'(cnt_reg);

    always_comb
    begin
        shadow_next = shadow_reg;
        wide_next   = 1'b0;
        narrow_next = 1'b0;
        case (rscd_pkg::cmd_t'(cmd_item.command))
            rscd_pkg::CMD_SET:
            begin
                shadow_next = shadow_reg | cmd_item.mask_or_value;
                wide_next   = |(cmd_item.mask_or_value & rscd_pkg::WIDE_MASK);
                narrow_next = |(cmd_item.mask_or_value & rscd_pkg::NARROW_MASK);
            end
            rscd_pkg::CMD_CLEAR:
            begin
                shadow_next = shadow_reg & ~cmd_item.mask_or_value;
                wide_next   = |(cmd_item.mask_or_value & rscd_pkg::WIDE_MASK);
                narrow_next = |(cmd_item.mask_or_value & rscd_pkg::NARROW_MASK);
            end
            rscd_pkg::CMD_WRITE:
            begin
                shadow_next = cmd_item.mask_or_value;
                wide_next   = 1'b1;
                narrow_next = 1'b1;
            end
            default:
            begin
                shadow_next = shadow_reg;
            end
        endcase
    end

    always_comb
    begin
        item_next = '0;
        item_next.kind = ctrl.kind;
        case (ctrl.kind)
            rscd_pkg::KIND_WIDE:
            begin
                item_next.data_bit    = shadow_reg[wide_pos];
                item_next.latch_after = wide_last;
            end
            rscd_pkg::KIND_NARROW:
            begin
                item_next.data_bit    = shadow_reg[narrow_pos];
                item_next.latch_after = narrow_last;
            end
            default:
            begin
                item_next.direct_pin   = shadow_reg[DIRECT_PIN_BIT];
                item_next.shadow_word  = shadow_reg;
                item_next.any_selected = |(shadow_reg & mask_reg);
                item_next.last         = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            wide_reg      <= 1'b0;
            narrow_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                shadow_reg <= shadow_next;
                wide_reg   <= wide_next;
                narrow_reg <= narrow_next;
            end
            if (ctrl.clr_cnt || (fire && item_next.latch_after))
            begin
                cnt_reg <= '0;
            end
            else if (fire)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= cmd_item.mask_or_value;
        end
        if (fire)
        begin
            out_item_reg <= item_next;
        end
    end

    always_comb
    begin
        flags.in_valid    = cmd_valid;
        flags.wide        = wide_reg;
        flags.narrow      = narrow_reg;
        flags.wide_last   = wide_last;
        flags.narrow_last = narrow_last;
        flags.out_free    = out_free;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    // The bit counter never runs past the end of the wide chain.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) < WIDE_CHAIN_BITS)
        else $error("chain bit counter out of range");

    // A query leaves the shadow word alone.
    a_query_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_item.command == rscd_pkg::CMD_QUERY) |=> $stable(shadow_reg))
        else $error("query changed the shadow word");

    // A status item reports the direct pin from its own shadow word.
    a_status_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.kind == rscd_pkg::KIND_STATUS)
            |-> (out_item_reg.last
                 && out_item_reg.direct_pin == out_item_reg.shadow_word[DIRECT_PIN_BIT]))
        else $error("status item inconsistent");
`endif

endmodule

// ===== tb/sv/relay_shift_chain_driver_tb.sv =====
`timescale 1ns / 1ps

module relay_shift_chain_driver_tb;

    import rscd_pkg::*;

    // A write shifts both chains, so it is among the longest commands. Even with both sides idling and one
    // long hold-off, a full run stays far below this limit.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PERCENT = 17;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    in_item_t    cmd_item;
    logic        res_valid;
    logic        res_stall;
    out_item_t   res_item;

    // This is our own copy of the relay shadow word. It is advanced once for each
    // command that the block accepts.
    logic [31:0] relay_word;
    out_item_t   pending_results[$];

    int          failure_count;
    int          cycle_count;
    bit          tx_idling;
    bit          rx_idling;
    int          hold_requests;
    int          hold_served;
    int          hold_left;

    relay_shift_chain_driver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item (cmd_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item (res_item)
    );

    always #4 clk = ~clk;

    // The run has a hard stop, so that a hung handshake cannot run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every failure is counted. Only the first ten are printed, so that one broken
    // path cannot flood the log.
    function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
        failure_count++;
        if (failure_count <= 10)
        begin
            $display("MISMATCH %s: expected 0x%08h, got 0x%08h (cycle %0d)",
                     what, want, got, cycle_count);
        end
    endfunction

    // This applies one command to the shadow word and queues the result items that the
    // block owes for it. Wide chain bits come first, then narrow chain bits, and the
    // status item always comes last.
    function automatic void predict_chain_items(cmd_t op, logic [31:0] arg);
        out_item_t item;
        bit        shift_wide;
        bit        shift_narrow;
        int        pos;

        shift_wide   = 1'b0;
        shift_narrow = 1'b0;
        case (op)
            CMD_SET:
            begin
                relay_word   = relay_word | arg;
                shift_wide   = (arg & WIDE_MASK) != 0;
                shift_narrow = (arg & NARROW_MASK) != 0;
            end
            CMD_CLEAR:
            begin
                relay_word   = relay_word & ~arg;
                shift_wide   = (arg & WIDE_MASK) != 0;
                shift_narrow = (arg & NARROW_MASK) != 0;
            end
            CMD_WRITE:
            begin
                relay_word   = arg;
                shift_wide   = 1'b1;
                shift_narrow = 1'b1;
            end
            default:
            begin
                // A query leaves the shadow word alone and shifts nothing.
            end
        endcase

        // The wide chain takes each byte from its most significant bit down, low byte first.
        if (shift_wide)
        begin
            for (int i = 0; i < WIDE_CHAIN_BITS_DEF; i++)
            begin
                pos              = 8 * (i / 8) + 7 - (i % 8);
                item             = '0;
                item.kind        = KIND_WIDE;
                item.data_bit    = relay_word[pos];
                item.latch_after = (i == WIDE_CHAIN_BITS_DEF - 1);
                pending_results.push_back(item);
            end
        end

        // The narrow chain walks bits 23 down to 16.
        if (shift_narrow)
        begin
            for (int i = 0; i < NARROW_CHAIN_BITS_DEF; i++)
            begin
                item             = '0;
                item.kind        = KIND_NARROW;
                item.data_bit    = relay_word[23 - i];
                item.latch_after = (i == NARROW_CHAIN_BITS_DEF - 1);
                pending_results.push_back(item);
            end
        end

        item              = '0;
        item.kind         = KIND_STATUS;
        item.direct_pin   = relay_word[DIRECT_PIN_BIT_DEF];
        item.shadow_word  = relay_word;
        item.any_selected = (relay_word & arg) != 0;
        item.last         = 1'b1;
        pending_results.push_back(item);
    endfunction

    // This compares one accepted result item, field by field, with the oldest expected one.
    task automatic check_result(out_item_t got);
        out_item_t want;

        if (pending_results.size() == 0)
        begin
            note_failure("result item with nothing expected", '0, 32'(got));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                note_failure("kind", 32'(want.kind), 32'(got.kind));
            if (got.data_bit != want.data_bit)
                note_failure("data_bit", 32'(want.data_bit), 32'(got.data_bit));
            if (got.latch_after != want.latch_after)
                note_failure("latch_after", 32'(want.latch_after), 32'(got.latch_after));
            if (got.direct_pin != want.direct_pin)
                note_failure("direct_pin", 32'(want.direct_pin), 32'(got.direct_pin));
            if (got.shadow_word !== want.shadow_word)
                note_failure("shadow_word", want.shadow_word, got.shadow_word);
            if (got.any_selected != want.any_selected)
                note_failure("any_selected", 32'(want.any_selected), 32'(got.any_selected));
            if (got.last != want.last)
                note_failure("last", 32'(want.last), 32'(got.last));
        end
    endtask

    // This is the result side. It checks every item taken at this edge and then decides
    // the stall for the next cycle. A hold-off request from a test task is not seen at the
    // edge where it is raised, because the request counter is raised with a nonblocking
    // assignment. The hold-off itself is counted down here.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_result(res_item);
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= rx_idling && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // This offers one command and waits until the block takes it. Random gaps come before
    // the offer, never while it stands, so a stalled item is held steady. Valid stays high
    // at the end, so back-to-back commands need no second assignment in one step.
    task automatic send_command(cmd_t op, logic [31:0] arg);
        while (tx_idling && ($urandom_range(99) < IDLE_PERCENT))
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid              <= 1'b1;
        cmd_item.command       <= op;
        cmd_item.mask_or_value <= arg;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_chain_items(op, arg);
    endtask

    // This picks a random mask or word. Most picks are confined to one chain or to the
    // top byte, so that each shift decision is reached often.
    function automatic logic [31:0] random_operand();
        logic [31:0] pick;

        case ($urandom_range(5))
            0:       pick = $urandom;
            1:       pick = 32'h1 << $urandom_range(31);
            2:       pick = $urandom & WIDE_MASK;
            3:       pick = $urandom & NARROW_MASK;
            4:       pick = $urandom & 32'hff00_0000;
            default: pick = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        endcase
        return pick;
    endfunction

    // These cover the edge values of both fields, every command, and the cases where a
    // command shifts one chain, both chains or none.
    task automatic test_directed_commands();
        send_command(CMD_QUERY, 32'hffff_ffff);    // The query sees the reset state.
        send_command(CMD_WRITE, 32'h0000_0000);
        send_command(CMD_WRITE, 32'hffff_ffff);
        send_command(CMD_QUERY, 32'h0000_0000);
        send_command(CMD_CLEAR, 32'h0000_0000);    // Only a status item results.
        send_command(CMD_SET, 32'h0000_0000);
        send_command(CMD_CLEAR, 32'hffff_ffff);
        send_command(CMD_SET, 32'h0000_0001);      // This shifts only the wide chain.
        send_command(CMD_SET, 32'h0000_8000);
        send_command(CMD_SET, 32'h0001_0000);      // This shifts only the narrow chain.
        send_command(CMD_SET, 32'h0080_0000);
        send_command(CMD_SET, 32'h0100_0000);      // Top byte only: the direct pin rises.
        send_command(CMD_QUERY, 32'h0100_0000);
        send_command(CMD_CLEAR, 32'h0100_0000);    // The direct pin falls, with no shift.
        send_command(CMD_SET, 32'h8000_0000);
        send_command(CMD_WRITE, 32'ha5c3_5a3c);
        send_command(CMD_CLEAR, 32'h0080_8000);    // This shifts both chains.
        send_command(CMD_SET, 32'h00ff_ffff);
        send_command(CMD_QUERY, 32'h0000_0001);
        send_command(CMD_WRITE, 32'h5a3c_a5c3);
        send_command(CMD_CLEAR, 32'hff00_0000);
        send_command(CMD_QUERY, 32'hffff_ffff);
    endtask

    // This is the bulk of the run: random commands and operands, with both sides idling.
    task automatic test_random_commands(int count);
        for (int n = 0; n < count; n++)
            send_command(cmd_t'($urandom_range(3)), random_operand());
    endtask

    // Here the receiver holds off for a long time while commands keep coming. The output
    // register fills, and the block must stall its command input without losing an item.
    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 12; n++)
            send_command(($urandom_range(1) ? CMD_WRITE : cmd_t'($urandom_range(3))),
                         random_operand());
    endtask

    // This is a stretch with no idling on either side, so commands run back to back.
    task automatic test_back_to_back();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_commands(40);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_item      = '0;
        res_stall     = 1'b0;
        relay_word    = '0;
        failure_count = 0;
        cycle_count   = 0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_random_commands(140);
        test_output_backpressure();
        test_back_to_back();
        test_random_commands(140);

        cmd_valid <= 1'b0;
        // All expected items must arrive first. Then a short quiet spell shows that no
        // stray item follows.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
